// ----- hw/rtl/dsky_keyboard_entry_unit_macros.svh -----
// assertion helpers for the keyboard entry unit
// every check samples on the rising clock edge and is idle in reset
`ifndef DSKY_KEYBOARD_ENTRY_UNIT_MACROS_SVH
`define DSKY_KEYBOARD_ENTRY_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define DSKE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define DSKE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/dske_pkg.sv -----
// ----------------------------------------------------------------------------
// dske_pkg
// Key codes, event codes and verb numbers of the keyboard entry unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dske_pkg;

  // keyboard codes
  localparam logic [4:0] KEY_ZERO   = 5'd16;
  localparam logic [4:0] KEY_VERB   = 5'd17;
  localparam logic [4:0] KEY_RSET   = 5'd18;
  localparam logic [4:0] KEY_REL    = 5'd25;
  localparam logic [4:0] KEY_PLUS   = 5'd26;
  localparam logic [4:0] KEY_MINUS  = 5'd27;
  localparam logic [4:0] KEY_ENTER  = 5'd28;
  localparam logic [4:0] KEY_CLR    = 5'd30;
  localparam logic [4:0] KEY_NOUN   = 5'd31;
  localparam logic [4:0] KEY_DIG_LO = 5'd1;
  localparam logic [4:0] KEY_DIG_HI = 5'd9;

  // verbs with their own enter action
  localparam logic [6:0] VERB_01 = 7'd1;
  localparam logic [6:0] VERB_11 = 7'd11;
  localparam logic [6:0] VERB_21 = 7'd21;
  localparam logic [6:0] VERB_22 = 7'd22;
  localparam logic [6:0] VERB_23 = 7'd23;
  localparam logic [6:0] VERB_24 = 7'd24;
  localparam logic [6:0] VERB_25 = 7'd25;
  localparam logic [6:0] VERB_33 = 7'd33;
  localparam logic [6:0] VERB_34 = 7'd34;
  localparam logic [6:0] VERB_37 = 7'd37;

  // noun that arms the load verbs, program that sends PRO to standby
  localparam logic [6:0] NOUN_02    = 7'd2;
  localparam logic [6:0] PROG_STBY  = 7'd6;

  // highest octal digit
  localparam logic [3:0] OCT_MAX = 4'd7;

  // entry lengths
  localparam logic [2:0] TWO_DIGITS  = 3'd2;
  localparam logic [2:0] FIVE_DIGITS = 3'd5;

  // data register slots, zero means no data entry
  localparam logic [1:0] SLOT_NONE = 2'd0;
  localparam logic [1:0] SLOT_R1   = 2'd1;
  localparam logic [1:0] SLOT_R2   = 2'd2;
  localparam logic [1:0] SLOT_R3   = 2'd3;

  // event reported with each result
  typedef enum logic [2:0] {
    EVT_NONE      = 3'd0,
    EVT_VERB_NOUN = 3'd1,
    EVT_PRO       = 3'd2,
    EVT_PROCEED   = 3'd3,
    EVT_TERMINATE = 3'd4,
    EVT_RESET     = 3'd5,
    EVT_STARTUP   = 3'd6,
    EVT_STANDBY   = 3'd7
  } evt_code_e;

endpackage

`default_nettype wire

// ----- hw/rtl/dske_if.sv -----
// ----------------------------------------------------------------------------
// dske channel interfaces
// Valid/ready channels for key events in and results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dske_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [4:0] key_code;
  logic       out_of_reset;
  logic       standby;
  logic [6:0] running_program;

  modport source (output valid, command, key_code, out_of_reset, standby,
                  running_program, input ready);
  modport sink   (input valid, command, key_code, out_of_reset, standby,
                  running_program, output ready);
endinterface

interface dske_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         event_res;
  logic               also_verb_noun;
  logic [6:0]         verb_value;
  logic [6:0]         noun_value;
  logic signed [17:0] reg_one;
  logic signed [17:0] reg_two;
  logic signed [17:0] reg_three;
  logic               operator_error;
  logic               keyboard_busy;
  logic               verb_noun_flash;

  modport source (output valid, event_res, also_verb_noun, verb_value, noun_value,
                  reg_one, reg_two, reg_three, operator_error, keyboard_busy,
                  verb_noun_flash, input ready);
  modport sink   (input valid, event_res, also_verb_noun, verb_value, noun_value,
                  reg_one, reg_two, reg_three, operator_error, keyboard_busy,
                  verb_noun_flash, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dsky_keyboard_entry_unit.sv -----
// ----------------------------------------------------------------------------
// dsky_keyboard_entry_unit
// Keyboard entry sequencer: verb, noun and data register entry per key event.
// ----------------------------------------------------------------------------
// Each key event passes an input register, combinational step logic and a
// result register, which holds the result until it is taken, and a new
// event is taken every cycle while the result side keeps up. The rate is
// set by the step logic that updates the entry state; the result register
// lets the next event in while a result waits. Every event gives exactly
// one result carrying an event code and the registers after the event. An
// operator error stays latched until RSET.
`timescale 1ns / 1ps
`default_nettype none

`include "dsky_keyboard_entry_unit_macros.svh"

module dsky_keyboard_entry_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dske_in_if.sink   key_i,
  dske_out_if.source res_o
);

  // input stage
  logic       in_v_q;
  logic       cmd_q;
  logic [4:0] code_q;
  logic       live_q;
  logic       stby_q;
  logic [6:0] prog_q;

  // result stage
  logic                 out_v_q;
  dske_pkg::evt_code_e  evt_q;
  logic                 also_q;
  logic [6:0]           verb_out_q;
  logic [6:0]           noun_out_q;
  logic [17:0]          r1_out_q, r2_out_q, r3_out_q;
  logic                 err_out_q, busy_out_q, flash_out_q;

  // entry state
  logic [6:0]  verb_q, verb_d;
  logic [6:0]  noun_q, noun_d;
  logic [17:0] data_q [3];
  logic [17:0] data_d [3];
  logic        ent_verb_q, ent_verb_d;
  logic        ent_noun_q, ent_noun_d;
  logic [1:0]  target_q, target_d;
  logic [1:0]  last_q, last_d;
  logic [2:0]  pos_q, pos_d;
  logic [17:0] val_q, val_d;
  logic        octal_q, octal_d;
  logic        positive_q, positive_d;
  logic        busy_q, busy_d;
  logic        err_q, err_d;
  logic        flash_q, flash_d;

  // step results
  dske_pkg::evt_code_e evt_d;
  logic                also_d;

  logic       adv;
  logic       is_digit;
  logic [3:0] dval;
  logic [2:0] next_slot;

  // handshake
  assign adv         = in_v_q && (!out_v_q || res_o.ready);
  assign key_i.ready = !in_v_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (key_i.ready) begin
      in_v_q <= key_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      cmd_q  <= key_i.command;
      code_q <= key_i.key_code;
      live_q <= key_i.out_of_reset;
      stby_q <= key_i.standby;
      prog_q <= key_i.running_program;
    end
  end

  // digit decode
  assign is_digit = (code_q >= dske_pkg::KEY_DIG_LO && code_q <= dske_pkg::KEY_DIG_HI) ||
                    (code_q == dske_pkg::KEY_ZERO);
  assign dval     = (code_q == dske_pkg::KEY_ZERO) ? 4'd0 : code_q[3:0];
  assign next_slot = {1'b0, target_q} + 3'd1;

  // step logic for one key event
  always_comb begin
    verb_d     = verb_q;
    noun_d     = noun_q;
    data_d     = data_q;
    ent_verb_d = ent_verb_q;
    ent_noun_d = ent_noun_q;
    target_d   = target_q;
    last_d     = last_q;
    pos_d      = pos_q;
    val_d      = val_q;
    octal_d    = octal_q;
    positive_d = positive_q;
    busy_d     = busy_q;
    err_d      = err_q;
    flash_d    = flash_q;
    evt_d      = dske_pkg::EVT_NONE;
    also_d     = 1'b0;

    if (live_q) begin
      if (cmd_q) begin
        // pro key
        priority if (stby_q) begin
          evt_d = dske_pkg::EVT_STARTUP;
        end else if (prog_q == dske_pkg::PROG_STBY) begin
          evt_d = dske_pkg::EVT_STANDBY;
        end else begin
          also_d = (verb_q == dske_pkg::VERB_01) || (verb_q == dske_pkg::VERB_11) ||
                   (verb_q == dske_pkg::VERB_21);
          evt_d  = dske_pkg::EVT_PRO;
          if (noun_q == dske_pkg::NOUN_02) begin
            priority if (verb_q == dske_pkg::VERB_01) begin
              target_d = dske_pkg::SLOT_R1;
              last_d   = dske_pkg::SLOT_R1;
              pos_d    = 3'd0;
            end else if (verb_q == dske_pkg::VERB_11) begin
              flash_d = 1'b0;
            end else if (verb_q == dske_pkg::VERB_21) begin
              target_d = dske_pkg::SLOT_R1;
              last_d   = dske_pkg::SLOT_R2;
              pos_d    = 3'd0;
            end else begin
              flash_d = flash_q;
            end
          end
        end
      end else if (!stby_q) begin
        if (is_digit) begin
          // digit keys
          priority if (octal_q && dval > dske_pkg::OCT_MAX) begin
            err_d = 1'b1;
          end else if (ent_verb_q || ent_noun_q) begin
            if (pos_q >= dske_pkg::TWO_DIGITS) begin
              err_d = 1'b1;
            end else begin
              val_d = (pos_q == 3'd0) ? (18'({dval, 3'b000}) + 18'({dval, 1'b0}))
                                      : (val_q + 18'(dval));
              pos_d = pos_q + 3'd1;
            end
          end else if (target_q != dske_pkg::SLOT_NONE) begin
            // bare first digit starts octal entry
            if (pos_q == 3'd0) begin
              pos_d      = 3'd1;
              val_d      = 18'd0;
              octal_d    = 1'b1;
              positive_d = 1'b1;
            end
            if (octal_d && dval > dske_pkg::OCT_MAX) begin
              err_d = 1'b1;
            end else begin
              val_d = octal_d ? ({val_d[14:0], 3'b000} + 18'(dval))
                              : ({val_d[14:0], 3'b000} + {val_d[16:0], 1'b0} + 18'(dval));
              pos_d = pos_d + 3'd1;
              // fifth digit stores the value and moves to the next register
              if (pos_d > dske_pkg::FIVE_DIGITS) begin
                if (!positive_d) begin
                  val_d = ~val_d + 18'd1;
                end
                data_d[target_q - 2'd1] = val_d;
                busy_d   = 1'b0;
                pos_d    = 3'd0;
                target_d = (next_slot > {1'b0, last_q} || next_slot > {1'b0, dske_pkg::SLOT_R3})
                           ? dske_pkg::SLOT_NONE : next_slot[1:0];
              end
            end
          end else begin
            err_d = 1'b1;
          end
        end else begin
          unique case (code_q)
            dske_pkg::KEY_VERB: begin
              if (ent_noun_q) begin
                err_d = 1'b1;
              end else begin
                flash_d    = 1'b0;
                pos_d      = 3'd0;
                val_d      = 18'd0;
                busy_d     = 1'b1;
                ent_verb_d = 1'b1;
              end
            end
            dske_pkg::KEY_RSET: begin
              err_d = 1'b0;
              evt_d = dske_pkg::EVT_RESET;
            end
            dske_pkg::KEY_REL: begin
              busy_d = 1'b0;
            end
            dske_pkg::KEY_PLUS, dske_pkg::KEY_MINUS: begin
              // signed decimal entry
              if (target_q != dske_pkg::SLOT_NONE && pos_q == 3'd0) begin
                positive_d = (code_q == dske_pkg::KEY_PLUS);
                pos_d      = 3'd1;
                val_d      = 18'd0;
                octal_d    = 1'b0;
              end else begin
                err_d = 1'b1;
              end
            end
            dske_pkg::KEY_ENTER: begin
              if (ent_verb_q) begin
                if (pos_q != dske_pkg::TWO_DIGITS) begin
                  err_d = 1'b1;
                end else begin
                  verb_d     = val_q[6:0];
                  ent_verb_d = 1'b0;
                  busy_d     = 1'b0;
                  flash_d    = 1'b0;
                  unique case (val_q[6:0])
                    dske_pkg::VERB_01, dske_pkg::VERB_11: begin
                      if (noun_q != dske_pkg::NOUN_02) begin
                        err_d = 1'b1;
                      end else begin
                        flash_d  = 1'b1;
                        target_d = dske_pkg::SLOT_R1;
                        last_d   = dske_pkg::SLOT_R1;
                        pos_d    = 3'd0;
                      end
                    end
                    dske_pkg::VERB_21: begin
                      flash_d  = (noun_q == dske_pkg::NOUN_02);
                      target_d = dske_pkg::SLOT_R1;
                      last_d   = (noun_q == dske_pkg::NOUN_02) ? dske_pkg::SLOT_R2
                                                               : dske_pkg::SLOT_R1;
                      pos_d    = 3'd0;
                    end
                    dske_pkg::VERB_22: begin
                      target_d = dske_pkg::SLOT_R2;
                      last_d   = dske_pkg::SLOT_R2;
                      pos_d    = 3'd0;
                    end
                    dske_pkg::VERB_23: begin
                      target_d = dske_pkg::SLOT_R3;
                      last_d   = dske_pkg::SLOT_R3;
                      pos_d    = 3'd0;
                    end
                    dske_pkg::VERB_24: begin
                      target_d = dske_pkg::SLOT_R1;
                      last_d   = dske_pkg::SLOT_R2;
                      pos_d    = 3'd0;
                    end
                    dske_pkg::VERB_25: begin
                      target_d = dske_pkg::SLOT_R1;
                      last_d   = dske_pkg::SLOT_R3;
                      pos_d    = 3'd0;
                    end
                    dske_pkg::VERB_33: evt_d = dske_pkg::EVT_PROCEED;
                    dske_pkg::VERB_34: evt_d = dske_pkg::EVT_TERMINATE;
                    dske_pkg::VERB_37: begin
                      pos_d      = 3'd0;
                      val_d      = 18'd0;
                      busy_d     = 1'b1;
                      ent_noun_d = 1'b1;
                    end
                    default: evt_d = dske_pkg::EVT_VERB_NOUN;
                  endcase
                end
              end else if (ent_noun_q) begin
                if (pos_q != dske_pkg::TWO_DIGITS) begin
                  err_d = 1'b1;
                end else begin
                  noun_d     = val_q[6:0];
                  ent_noun_d = 1'b0;
                  busy_d     = 1'b0;
                  evt_d      = dske_pkg::EVT_VERB_NOUN;
                end
              end
            end
            dske_pkg::KEY_CLR: begin
              if (target_q != dske_pkg::SLOT_NONE) begin
                pos_d = 3'd0;
              end else begin
                err_d = 1'b1;
              end
            end
            dske_pkg::KEY_NOUN: begin
              if (ent_verb_q && pos_q != dske_pkg::TWO_DIGITS) begin
                err_d = 1'b1;
              end else begin
                if (ent_verb_q) begin
                  verb_d     = val_q[6:0];
                  ent_verb_d = 1'b0;
                end
                pos_d      = 3'd0;
                val_d      = 18'd0;
                busy_d     = 1'b1;
                ent_noun_d = 1'b1;
              end
            end
            default: evt_d = dske_pkg::EVT_NONE;
          endcase
        end
      end
    end
  end

  // entry state update on each transfer into the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verb_q     <= 7'd0;
      noun_q     <= 7'd0;
      data_q[0]  <= 18'd0;
      data_q[1]  <= 18'd0;
      data_q[2]  <= 18'd0;
      ent_verb_q <= 1'b0;
      ent_noun_q <= 1'b0;
      target_q   <= dske_pkg::SLOT_NONE;
      last_q     <= dske_pkg::SLOT_NONE;
      pos_q      <= 3'd0;
      val_q      <= 18'd0;
      octal_q    <= 1'b0;
      positive_q <= 1'b1;
      busy_q     <= 1'b0;
      err_q      <= 1'b0;
      flash_q    <= 1'b0;
    end else if (adv) begin
      verb_q     <= verb_d;
      noun_q     <= noun_d;
      data_q     <= data_d;
      ent_verb_q <= ent_verb_d;
      ent_noun_q <= ent_noun_d;
      target_q   <= target_d;
      last_q     <= last_d;
      pos_q      <= pos_d;
      val_q      <= val_d;
      octal_q    <= octal_d;
      positive_q <= positive_d;
      busy_q     <= busy_d;
      err_q      <= err_d;
      flash_q    <= flash_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      evt_q       <= evt_d;
      also_q      <= also_d;
      verb_out_q  <= verb_d;
      noun_out_q  <= noun_d;
      r1_out_q    <= data_d[0];
      r2_out_q    <= data_d[1];
      r3_out_q    <= data_d[2];
      err_out_q   <= err_d;
      busy_out_q  <= busy_d;
      flash_out_q <= flash_d;
    end
  end

  assign res_o.valid           = out_v_q;
  assign res_o.event_res       = evt_q;
  assign res_o.also_verb_noun  = also_q;
  assign res_o.verb_value      = verb_out_q;
  assign res_o.noun_value      = noun_out_q;
  assign res_o.reg_one         = r1_out_q;
  assign res_o.reg_two         = r2_out_q;
  assign res_o.reg_three       = r3_out_q;
  assign res_o.operator_error  = err_out_q;
  assign res_o.keyboard_busy   = busy_out_q;
  assign res_o.verb_noun_flash = flash_out_q;

  // checks
  `DSKE_ASSERT_NEVER(a_one_two_digit_entry, ent_verb_q && ent_noun_q,
                     "verb and noun entry active together")
  `DSKE_ASSERT_NEVER(a_digit_pos_range, pos_q > dske_pkg::FIVE_DIGITS,
                     "digit position beyond five")
  `DSKE_ASSERT(a_rset_clears_error,
               adv && live_q && !cmd_q && !stby_q && code_q == dske_pkg::KEY_RSET |=> !err_q,
               "operator error not cleared by RSET")
  `DSKE_ASSERT(a_result_from_input, $rose(out_v_q) |-> $past(in_v_q),
               "result shown without an event in the input stage")
  `DSKE_ASSERT(a_state_holds_on_stall,
               in_v_q && !adv |=> $stable(verb_q) && $stable(noun_q) && $stable(err_q),
               "entry state changed while the result stage stalled")

endmodule

`default_nettype wire
